// File: rtl/core/tlte_pkg.sv
// Shared types and constants for the tile link table engine.
// No dependencies; used by every module under rtl/core.
package tlte_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR     = 3'd0,
    OP_ADD_ENT   = 3'd1,
    OP_SET_EXIT  = 3'd2,
    OP_FIND_ENT  = 3'd3,
    OP_FIND_EXIT = 3'd4,
    OP_HIT       = 3'd5,
    OP_BAD6      = 3'd6,
    OP_BAD7      = 3'd7
  } op_e;

  localparam int unsigned SCREEN_LIMIT = 7;
  localparam int unsigned TILE_PIXELS  = 8;

  // Classified request as it travels from the front to the back.
  typedef struct packed {
    op_e         op;
    logic        pos_ok;
    logic [2:0]  scol;
    logic [2:0]  srow;
    logic        sc_hi;
    logic [5:0]  tcol;
    logic [5:0]  trow;
    logic [5:0]  link;
    logic [7:0]  flags;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [11:0] pw;
    logic [11:0] ph;
  } req_t;

endpackage

// File: rtl/core/tlte_front.sv
// Front part: takes requests, checks positions, pushes to a two-entry queue.
// Depends on tlte_pkg.
module tlte_front #(
  parameter int unsigned TILES_X = 32,
  parameter int unsigned TILES_Y = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [2:0]        op_i,
  input  logic [3:0]        screen_col_i,
  input  logic [3:0]        screen_row_i,
  input  logic [5:0]        tile_col_i,
  input  logic [5:0]        tile_row_i,
  input  logic [5:0]        entrance_index_i,
  input  logic [7:0]        exit_flags_i,
  input  logic signed [15:0] player_x_i,
  input  logic signed [15:0] player_y_i,
  input  logic [11:0]       player_w_i,
  input  logic [11:0]       player_h_i,
  output logic              q_valid_o,
  output tlte_pkg::req_t    q_req_o,
  input  logic              q_pop_i
);
  import tlte_pkg::*;

  req_t        mem_q [2];
  logic        wr_q, rd_q, wr_d, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  req_t        req;
  logic        push;

  always_comb begin
    req.op     = op_e'(op_i);
    req.pos_ok = (32'(screen_col_i) <= SCREEN_LIMIT) && (32'(screen_row_i) <= SCREEN_LIMIT)
                 && (32'(tile_col_i) < TILES_X) && (32'(tile_row_i) < TILES_Y);
    req.scol   = screen_col_i[2:0];
    req.srow   = screen_row_i[2:0];
    // find entrance compares full screen fields: a high bit matches nothing
    req.sc_hi  = screen_col_i[3] | screen_row_i[3];
    req.tcol   = tile_col_i;
    req.trow   = tile_row_i;
    req.link   = entrance_index_i;
    req.flags  = exit_flags_i;
    req.px     = player_x_i;
    req.py     = player_y_i;
    req.pw     = player_w_i;
    req.ph     = player_h_i;
  end

  assign busy_o    = (cnt_q == 2'd2);
  assign push      = start_i && !busy_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = q_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= req;
    end
  end

endmodule

// File: rtl/core/tlte_back.sv
// Back part: scans the entrance and exit tables one slot a cycle.
// Depends on tlte_pkg.
module tlte_back #(
  parameter int unsigned MAX_ENTRANCES   = 32,
  parameter int unsigned MAX_EXITS       = 32,
  parameter int unsigned SCREEN_PIXELS_W = 256,
  parameter int unsigned SCREEN_PIXELS_H = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  tlte_pkg::req_t q_req_i,
  output logic           q_pop_o,
  output logic           done_o,
  output logic           ok_o,
  output logic [5:0]     slot_index_o
);
  import tlte_pkg::*;

  localparam int unsigned NE = MAX_ENTRANCES;
  localparam int unsigned NX = MAX_EXITS;
  localparam int unsigned EW = (NE > 1) ? $clog2(NE) : 1;
  localparam int unsigned XW = (NX > 1) ? $clog2(NX) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_ENT_SCAN, S_FREE_SCAN, S_EXIT_SCAN, S_EXIT_WB, S_DONE
  } state_e;

  state_e      state_q;
  req_t        req_q;
  logic [6:0]  idx_q;
  logic [6:0]  ehm_q, xhm_q;
  logic        found_q;
  logic [5:0]  slot_q;

  logic        ent_v_q [NE];
  logic [2:0]  ent_sc_q [NE];
  logic [2:0]  ent_sr_q [NE];
  logic [5:0]  ent_tc_q [NE];
  logic [5:0]  ent_tr_q [NE];
  logic        ext_v_q [NX];
  logic [5:0]  ext_link_q [NX];
  logic [25:0] ext_dat_q [NX];

  logic [EW-1:0] ei;
  logic [XW-1:0] xi;
  logic          e_pos_eq, e_hit, x_eq;
  logic signed [19:0] tx, ty, px, py;
  logic signed [19:0] pxw, pyh;

  assign ei = idx_q[EW-1:0];
  assign xi = idx_q[XW-1:0];

  always_comb begin
    e_pos_eq = ent_v_q[ei] && !req_q.sc_hi && ent_sc_q[ei] == req_q.scol &&
               ent_sr_q[ei] == req_q.srow && ent_tc_q[ei] == req_q.tcol &&
               ent_tr_q[ei] == req_q.trow;
    tx  = 20'(32'(ent_sc_q[ei]) * SCREEN_PIXELS_W) + 20'({ent_tc_q[ei], 3'b000});
    ty  = 20'(32'(ent_sr_q[ei]) * SCREEN_PIXELS_H) + 20'({ent_tr_q[ei], 3'b000});
    px  = 20'(req_q.px);
    py  = 20'(req_q.py);
    pxw = px + $signed({8'd0, req_q.pw});
    pyh = py + $signed({8'd0, req_q.ph});
    e_hit = ent_v_q[ei] && (px < tx + 20'sd8) && (pxw > tx) &&
            (py < ty + 20'sd8) && (pyh > ty);
    x_eq = ext_v_q[xi] && ext_link_q[xi] == req_q.link;
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      ehm_q   <= '0;
      xhm_q   <= '0;
      found_q <= 1'b0;
      slot_q  <= '0;
      done_o  <= 1'b0;
      ok_o    <= 1'b0;
      slot_index_o <= '0;
      for (int i = 0; i < NE; i++) ent_v_q[i] <= 1'b0;
      for (int i = 0; i < NX; i++) ext_v_q[i] <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            req_q   <= q_req_i;
            idx_q   <= '0;
            found_q <= 1'b0;
            slot_q  <= '0;
            case (q_req_i.op)
              OP_CLEAR: begin
                for (int i = 0; i < NE; i++) ent_v_q[i] <= 1'b0;
                for (int i = 0; i < NX; i++) ext_v_q[i] <= 1'b0;
                ehm_q   <= '0;
                xhm_q   <= '0;
                found_q <= 1'b1;
                state_q <= S_DONE;
              end
              OP_ADD_ENT: state_q <= q_req_i.pos_ok ? S_ENT_SCAN : S_DONE;
              OP_FIND_ENT, OP_HIT: state_q <= S_ENT_SCAN;
              OP_SET_EXIT: begin
                if (q_req_i.pos_ok && 32'(q_req_i.link) < NE &&
                    ent_v_q[q_req_i.link[EW-1:0]]) begin
                  state_q <= S_EXIT_SCAN;
                end else begin
                  state_q <= S_DONE;
                end
              end
              OP_FIND_EXIT: state_q <= S_EXIT_SCAN;
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_ENT_SCAN: begin
          if (idx_q >= ehm_q || 32'(idx_q) >= NE) begin
            idx_q   <= '0;
            state_q <= (req_q.op == OP_ADD_ENT) ? S_FREE_SCAN : S_DONE;
          end else if ((req_q.op == OP_HIT) ? e_hit : e_pos_eq) begin
            found_q <= 1'b1;
            slot_q  <= idx_q[5:0];
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + 7'd1;
          end
        end
        S_FREE_SCAN: begin
          if (32'(idx_q) >= NE) begin
            state_q <= S_DONE;
          end else if (!ent_v_q[ei]) begin
            ent_v_q[ei]  <= 1'b1;
            ent_sc_q[ei] <= req_q.scol;
            ent_sr_q[ei] <= req_q.srow;
            ent_tc_q[ei] <= req_q.tcol;
            ent_tr_q[ei] <= req_q.trow;
            if (idx_q >= ehm_q) ehm_q <= idx_q + 7'd1;
            found_q <= 1'b1;
            slot_q  <= idx_q[5:0];
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + 7'd1;
          end
        end
        S_EXIT_SCAN: begin
          if (req_q.op == OP_FIND_EXIT) begin
            if (idx_q >= xhm_q || 32'(idx_q) >= NX) begin
              state_q <= S_DONE;
            end else if (x_eq) begin
              found_q <= 1'b1;
              slot_q  <= idx_q[5:0];
              state_q <= S_DONE;
            end else begin
              idx_q <= idx_q + 7'd1;
            end
          end else begin
            // set exit: a match overrides the first free slot seen so far
            if (32'(idx_q) >= NX || x_eq) begin
              if (32'(idx_q) < NX) begin
                found_q <= 1'b1;
                slot_q  <= idx_q[5:0];
              end
              state_q <= (found_q || (32'(idx_q) < NX)) ? S_EXIT_WB : S_DONE;
            end else begin
              if (!found_q && !ext_v_q[xi]) begin
                found_q <= 1'b1;
                slot_q  <= idx_q[5:0];
              end
              idx_q <= idx_q + 7'd1;
            end
          end
        end
        S_EXIT_WB: begin
          ext_v_q[slot_q[XW-1:0]]    <= 1'b1;
          ext_link_q[slot_q[XW-1:0]] <= req_q.link;
          ext_dat_q[slot_q[XW-1:0]]  <= {req_q.scol, req_q.srow, req_q.tcol, req_q.trow,
                                         req_q.flags};
          if (7'(slot_q) >= xhm_q) xhm_q <= 7'(slot_q) + 7'd1;
          state_q <= S_DONE;
        end
        default: begin
          ok_o         <= found_q;
          slot_index_o <= found_q ? slot_q : 6'd0;
          done_o       <= 1'b1;
          state_q      <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/tile_link_table_engine.sv
// Top level of the tile link table engine: front queue plus table back end.
// Depends on tlte_pkg, tlte_front and tlte_back.
//
//  channel | direction | handshake
//  request | in        | start_i, busy_o
//  result  | out       | done_o strobe, one cycle
//
// The back end scans its tables one slot a cycle.
// Reset empties both tables at once through their valid bits.
// The front queue holds two requests; busy_o rises only when it is full.
module tile_link_table_engine #(
  parameter int unsigned MAX_ENTRANCES   = 32,
  parameter int unsigned MAX_EXITS       = 32,
  parameter int unsigned TILES_X         = 32,
  parameter int unsigned TILES_Y         = 32,
  parameter int unsigned SCREEN_PIXELS_W = 256,
  parameter int unsigned SCREEN_PIXELS_H = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [2:0]        op_i,
  input  logic [3:0]        screen_col_i,
  input  logic [3:0]        screen_row_i,
  input  logic [5:0]        tile_col_i,
  input  logic [5:0]        tile_row_i,
  input  logic [5:0]        entrance_index_i,
  input  logic [7:0]        exit_flags_i,
  input  logic signed [15:0] player_x_i,
  input  logic signed [15:0] player_y_i,
  input  logic [11:0]       player_w_i,
  input  logic [11:0]       player_h_i,
  output logic              done_o,
  output logic              ok_o,
  output logic [5:0]        slot_index_o
);
  import tlte_pkg::*;

  logic q_valid, q_pop;
  req_t q_req;

  tlte_front #(.TILES_X(TILES_X), .TILES_Y(TILES_Y)) u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .screen_col_i, .screen_row_i,
    .tile_col_i, .tile_row_i, .entrance_index_i, .exit_flags_i, .player_x_i,
    .player_y_i, .player_w_i, .player_h_i,
    .q_valid_o(q_valid), .q_req_o(q_req), .q_pop_i(q_pop)
  );

  tlte_back #(
    .MAX_ENTRANCES(MAX_ENTRANCES), .MAX_EXITS(MAX_EXITS),
    .SCREEN_PIXELS_W(SCREEN_PIXELS_W), .SCREEN_PIXELS_H(SCREEN_PIXELS_H)
  ) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_req_i(q_req), .q_pop_o(q_pop),
    .done_o, .ok_o, .slot_index_o
  );

endmodule
